### rtl/core/pscfc_pkg.sv
// Package for the pressure sensor frame checker: beat structs, status codes,
// reset values, byte positions of the frame and the CRC-8 byte update.
// No dependencies; every file of the block imports it.
package pscfc_pkg;

  localparam int FRAME_BYTES_DEF   = 9;
  localparam int FRACTION_BITS_DEF = 8;

  localparam int RAW_W = 16;
  localparam int Q_W   = 24;
  localparam int CFG_W = 16;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  localparam logic [CFG_W-1:0] PSCALE_RST = 16'd60;
  localparam logic [CFG_W-1:0] TSCALE_RST = 16'd200;

  // register indexes of the configuration port
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRES_SCALE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_SCALE = 1'b1;

  // byte positions inside a frame
  localparam int POS_P_HI  = 0;
  localparam int POS_P_LO  = 1;
  localparam int POS_P_CRC = 2;
  localparam int POS_T_HI  = 3;
  localparam int POS_T_LO  = 4;
  localparam int POS_T_CRC = 5;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_PRES_CRC = 2'd1,
    ST_TEMP_CRC = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV_P,
    S_DIV_T,
    S_LOAD
  } seq_state_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]            status;
    logic signed [Q_W-1:0] pressure_q8;
    logic signed [Q_W-1:0] temperature_q8;
  } out_beat_t;

  // what the parser hands to the sequencer at the end of a frame
  typedef struct packed {
    status_t          status;
    logic [RAW_W-1:0] pres_word;
    logic [RAW_W-1:0] temp_word;
  } frame_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // magnitude of a 16-bit two's complement word; 0x8000 gives 32768
  function automatic logic [RAW_W-1:0] raw_mag(input logic [RAW_W-1:0] raw);
    return raw[RAW_W-1] ? (~raw + 1'b1) : raw;
  endfunction

endpackage

### rtl/core/pscfc_divider.sv
// Shared restoring divider: one quotient bit per cycle, DVD_W quotient bits.
// Depends on pscfc_pkg for the divisor width.
module pscfc_divider #(
  parameter int DVD_W = 24
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [DVD_W-1:0]            dividend,
  input  logic [pscfc_pkg::RAW_W-1:0] divisor,
  output logic                        done,
  output logic [DVD_W-1:0]            quotient
);
  import pscfc_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [RAW_W-1:0] rem_r, rem_nxt;
  logic [RAW_W-1:0] dvs_r, dvs_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [RAW_W:0]   rem_sh;
  logic             ge;

  assign rem_sh = {rem_r, quo_r[DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DVD_W);
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      // shift the next dividend bit in, subtract where it fits
      rem_nxt = ge ? RAW_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[RAW_W-1:0];
      quo_nxt = {quo_r[DVD_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### rtl/core/pscfc_parser.sv
// Frame byte tracker: byte position, running CRC-8 and word capture.
// Depends on pscfc_pkg for beat types, positions and the CRC update.
module pscfc_parser #(
  parameter int FRAME_BYTES = 9
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  pscfc_pkg::in_beat_t beat,
  output logic                last_byte,
  output pscfc_pkg::frame_t   frame
);
  import pscfc_pkg::*;

  localparam int POS_W = $clog2(FRAME_BYTES);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       crc_r, crc_nxt;
  status_t          err_r, err_nxt;
  frame_t           frame_r, frame_nxt;

  logic [POS_W-1:0] pos_eff;
  logic [7:0]       crc_eff;
  status_t          err_eff;

  // frame_start restarts the frame before this byte is taken
  assign pos_eff   = beat.frame_start ? '0 : pos_r;
  assign crc_eff   = beat.frame_start ? CRC_INIT : crc_r;
  assign err_eff   = beat.frame_start ? ST_OK : err_r;
  assign last_byte = (int'(pos_eff) + 1) >= FRAME_BYTES;

  always_comb begin
    pos_nxt   = pos_r;
    crc_nxt   = crc_r;
    err_nxt   = err_r;
    frame_nxt = frame_r;
    if (accept) begin
      crc_nxt = crc_eff;
      err_nxt = err_eff;
      case (pos_eff)
        POS_W'(POS_P_HI): begin
          frame_nxt.pres_word[15:8] = beat.rx_byte;
          crc_nxt = crc8_update(crc_eff, beat.rx_byte);
        end
        POS_W'(POS_P_LO): begin
          frame_nxt.pres_word[7:0] = beat.rx_byte;
          crc_nxt = crc8_update(crc_eff, beat.rx_byte);
        end
        POS_W'(POS_P_CRC): begin
          if (crc_eff != beat.rx_byte && err_eff == ST_OK) err_nxt = ST_PRES_CRC;
          crc_nxt = CRC_INIT;
        end
        POS_W'(POS_T_HI): begin
          frame_nxt.temp_word[15:8] = beat.rx_byte;
          crc_nxt = crc8_update(crc_eff, beat.rx_byte);
        end
        POS_W'(POS_T_LO): begin
          frame_nxt.temp_word[7:0] = beat.rx_byte;
          crc_nxt = crc8_update(crc_eff, beat.rx_byte);
        end
        POS_W'(POS_T_CRC): begin
          if (crc_eff != beat.rx_byte && err_eff == ST_OK) err_nxt = ST_TEMP_CRC;
          crc_nxt = CRC_INIT;
        end
        default: begin
        end
      endcase
      if (last_byte) begin
        // latch the verdict, wrap for the next frame
        frame_nxt.status = err_nxt;
        pos_nxt = '0;
        crc_nxt = CRC_INIT;
        err_nxt = ST_OK;
      end else begin
        pos_nxt = pos_eff + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      crc_r   <= CRC_INIT;
      err_r   <= ST_OK;
      frame_r <= '{status: ST_OK, pres_word: '0, temp_word: '0};
    end else begin
      pos_r   <= pos_nxt;
      crc_r   <= crc_nxt;
      err_r   <= err_nxt;
      frame_r <= frame_nxt;
    end
  end

  assign frame = frame_r;

endmodule

### rtl/core/pressure_sensor_frame_checker_unit.sv
// Pressure sensor frame checker top level: config registers, sequencer,
// output register. Depends on pscfc_pkg, pscfc_parser and pscfc_divider.
//
// Usage:
//   in_*  : one frame byte per beat (rx_byte, frame_start), valid/ready.
//   out_* : one result per complete frame (status, pressure_q8,
//           temperature_q8), valid/ready.
//   cfg_* : write port, index 0 pressure_scale, 1 temperature_scale; a
//           scale of zero divides by one.
// Bytes other than the last of a frame are taken while the sequencer is
// idle. The last byte holds input low while both values are scaled: a
// check step, two passes of the shared bit-serial divider and a load
// step, after which the result is valid. A frame with a CRC failure
// skips the divider and goes straight from the check step to the load step.
// The result sits in an output register until taken; while it waits, the
// bytes of the next frame are accepted, and only the next frame's last byte
// holds in the load step until the register is free.
// Reset clears the byte position, CRC and error state, restores the scales
// to 60 and 200, and empties the output register.
module pressure_sensor_frame_checker_unit #(
  parameter int FRAME_BYTES   = pscfc_pkg::FRAME_BYTES_DEF,
  parameter int FRACTION_BITS = pscfc_pkg::FRACTION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  pscfc_pkg::in_beat_t             in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output pscfc_pkg::out_beat_t            out_data,
  input  logic                            cfg_we,
  input  logic [pscfc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pscfc_pkg::CFG_W-1:0]     cfg_wdata
);
  import pscfc_pkg::*;

  localparam int DVD_W = RAW_W + FRACTION_BITS;

  seq_state_t           state_r, state_nxt;
  logic [CFG_W-1:0]     pscale_r, pscale_nxt;
  logic [CFG_W-1:0]     tscale_r, tscale_nxt;
  logic signed [Q_W-1:0] pq_r, pq_nxt;
  logic signed [Q_W-1:0] tq_r, tq_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_beat_t            out_r, out_nxt;

  logic             accept;
  logic             last_byte;
  frame_t           frame;
  logic             div_start;
  logic             div_done;
  logic [DVD_W-1:0] div_dvd;
  logic [RAW_W-1:0] div_dvs;
  logic [DVD_W-1:0] div_quo;
  logic             sel_temp;
  logic             res_neg;
  logic [Q_W-1:0]   res_mag;
  logic signed [Q_W-1:0] res_q;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  pscfc_parser #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .beat     (in_data),
    .last_byte(last_byte),
    .frame    (frame)
  );

  pscfc_divider #(
    .DVD_W(DVD_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_dvd),
    .divisor (div_dvs),
    .done    (div_done),
    .quotient(div_quo)
  );

  // pressure goes first, temperature is loaded as pressure finishes
  assign sel_temp = (state_r == S_DIV_P);
  assign div_dvd  = DVD_W'(raw_mag(sel_temp ? frame.temp_word : frame.pres_word))
                    << FRACTION_BITS;
  assign div_dvs  = sel_temp ? ((tscale_r == '0) ? RAW_W'(1) : tscale_r)
                             : ((pscale_r == '0) ? RAW_W'(1) : pscale_r);

  assign res_neg = (state_r == S_DIV_T) ? frame.temp_word[RAW_W-1]
                                        : frame.pres_word[RAW_W-1];
  assign res_mag = Q_W'(div_quo);
  assign res_q   = res_neg ? $signed(Q_W'(0) - res_mag) : $signed(res_mag);

  always_comb begin
    pscale_nxt = pscale_r;
    tscale_nxt = tscale_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_PRES_SCALE: pscale_nxt = cfg_wdata;
        CFG_TEMP_SCALE: tscale_nxt = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    div_start     = 1'b0;
    pq_nxt        = pq_r;
    tq_nxt        = tq_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    case (state_r)
      S_IDLE: begin
        if (accept && last_byte) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (frame.status == ST_OK) begin
          div_start = 1'b1;
          state_nxt = S_DIV_P;
        end else begin
          pq_nxt    = '0;
          tq_nxt    = '0;
          state_nxt = S_LOAD;
        end
      end
      S_DIV_P: begin
        if (div_done) begin
          pq_nxt    = res_q;
          div_start = 1'b1;
          state_nxt = S_DIV_T;
        end
      end
      S_DIV_T: begin
        if (div_done) begin
          tq_nxt    = res_q;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt          = 1'b1;
          out_nxt.status         = frame.status;
          out_nxt.pressure_q8    = pq_r;
          out_nxt.temperature_q8 = tq_r;
          state_nxt              = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pscale_r    <= PSCALE_RST;
      tscale_r    <= TSCALE_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pscale_r    <= pscale_nxt;
      tscale_r    <= tscale_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pq_r  <= pq_nxt;
    tq_r  <= tq_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### rtl/core/pscfc_checker.sv
// Port-level checks for the pressure sensor frame checker, bound to the top.
// Depends on pscfc_pkg and pressure_sensor_frame_checker_unit.
module pscfc_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input pscfc_pkg::out_beat_t out_data
);
  import pscfc_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // failed frames carry zero values
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |->
      out_data.pressure_q8 == '0 && out_data.temperature_q8 == '0)
    else $error("failed frame carries nonzero values");

  // a new result is loaded only while input is held off
  a_load_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without a processing stall");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind pressure_sensor_frame_checker_unit pscfc_checker u_pscfc_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
